### hw/rtl/vsilt_pkg.sv
// Shared types and constants for the sync interval line tracker.
package vsilt_pkg;

  localparam int unsigned TICK_BITS = 16;
  localparam int unsigned CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] SHORT_FIELD_LINES  = 16'd10;
  localparam logic [15:0] FULL_FIELD_LINES   = 16'd300;
  localparam logic [15:0] PARTIAL_FIELD_BASE = 16'd305;

  localparam logic [15:0] RST_LINE_MIN    = 16'd10030;
  localparam logic [15:0] RST_LINE_MAX    = 16'd11050;
  localparam logic [15:0] RST_GOOD_MAX    = 16'd10795;
  localparam logic [15:0] RST_HALF_MIN    = 16'd4930;
  localparam logic [15:0] RST_HALF_MAX    = 16'd5610;
  localparam logic [9:0]  RST_LAST_RENDER = 10'd303;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_HALF  = 2'd1,
    KIND_NOISE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_LINE_MIN    = 3'd0,
    CFG_LINE_MAX    = 3'd1,
    CFG_GOOD_MAX    = 3'd2,
    CFG_HALF_MIN    = 3'd3,
    CFG_HALF_MAX    = 3'd4,
    CFG_LAST_RENDER = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] line_min;
    logic [15:0] line_max;
    logic [15:0] good_max;
    logic [15:0] half_min;
    logic [15:0] half_max;
    logic [9:0]  last_render;
  } cfg_t;

  // Classified interval handed from front to back.
  typedef struct packed {
    kind_e kind;
    logic  good;
  } item_t;

endpackage

### hw/rtl/video_sync_interval_line_tracker_top.sv
// Top level of the composite video sync interval line tracker.
// Each item is one measured time between two sync edges, in timer ticks.
// The front end sorts it into a full line, a half-line field pulse or
// noise by exclusive tick windows (the line window wins where the two
// overlap), and a two-entry queue hands the verdict to the back end, which
// keeps the line, good-line, noise and frame counters and the field flag.
// Every item yields exactly one result carrying the counters after that
// item. Throughput is one item per clock; each item passes through the
// queue and then the result register. The input stalls only while the
// queue is full, which happens once two items wait behind a stalled
// result. Threshold registers are written through the config channel, which
// is always ready; write them only while no item is in flight. Register
// indexes follow cfg_idx_e; writes to other indexes are dropped.
module video_sync_interval_line_tracker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [vsilt_pkg::TICK_BITS-1:0] interval_ticks_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      interval_kind_o,
  output logic [15:0]                     line_number_o,
  output logic                            draw_line_o,
  output logic [15:0]                     quality_score_o,
  output logic [15:0]                     noise_count_o,
  output logic [7:0]                      frame_count_o,
  output logic                            field_active_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [2:0]                      cfg_index_i,
  input  logic [15:0]                     cfg_data_i
);
  import vsilt_pkg::*;

  cfg_t  cfg_q;
  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  pop;
  logic  q_empty;
  logic  q_full;

  assign cfg_ready_o = 1'b1;

  // Threshold registers; values are kept at their field widths.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_min    <= RST_LINE_MIN;
      cfg_q.line_max    <= RST_LINE_MAX;
      cfg_q.good_max    <= RST_GOOD_MAX;
      cfg_q.half_min    <= RST_HALF_MIN;
      cfg_q.half_max    <= RST_HALF_MAX;
      cfg_q.last_render <= RST_LAST_RENDER;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_MIN:    cfg_q.line_min    <= cfg_data_i;
        CFG_LINE_MAX:    cfg_q.line_max    <= cfg_data_i;
        CFG_GOOD_MAX:    cfg_q.good_max    <= cfg_data_i;
        CFG_HALF_MIN:    cfg_q.half_min    <= cfg_data_i;
        CFG_HALF_MAX:    cfg_q.half_max    <= cfg_data_i;
        CFG_LAST_RENDER: cfg_q.last_render <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  vsilt_front u_front (
    .in_valid_i      (in_valid_i),
    .interval_ticks_i(interval_ticks_i),
    .cfg_i           (cfg_q),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .item_o          (push_item)
  );

  vsilt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  vsilt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (q_empty),
    .q_item_i       (pop_item),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .interval_kind_o(interval_kind_o),
    .line_number_o  (line_number_o),
    .draw_line_o    (draw_line_o),
    .quality_score_o(quality_score_o),
    .noise_count_o  (noise_count_o),
    .frame_count_o  (frame_count_o),
    .field_active_o (field_active_o)
  );

  // A field pulse always leaves the line count and field flag cleared.
  a_half_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (interval_kind_o == KIND_HALF) |->
      !field_active_o && (line_number_o == 16'd0))
    else $error("field pulse did not clear line state");

  // Only full lines are ever rendered.
  a_render_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && draw_line_o |-> (interval_kind_o == KIND_LINE))
    else $error("render flag on a non-line item");

  // A full line always leaves the field active.
  a_line_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (interval_kind_o == KIND_LINE) |-> field_active_o)
    else $error("full line left field inactive");

  // The queue always drains into the result slot while that slot is free and the queue holds items.
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_empty && !out_valid_o |=> out_valid_o)
    else $error("back end idled with queued items");

endmodule

### hw/rtl/vsilt_front.sv
// Front end: accepts intervals and sorts them against the tick windows.
module vsilt_front (
  input  logic                           in_valid_i,
  input  logic [vsilt_pkg::TICK_BITS-1:0] interval_ticks_i,
  input  vsilt_pkg::cfg_t                cfg_i,
  input  logic                           q_full_i,
  output logic                           in_stall_o,
  output logic                           push_o,
  output vsilt_pkg::item_t               item_o
);
  import vsilt_pkg::*;

  logic [CMP_W-1:0] t;
  logic             in_line;
  logic             in_half;

  assign t = CMP_W'(interval_ticks_i);

  always_comb begin
    in_line = (t > CMP_W'(cfg_i.line_min)) && (t < CMP_W'(cfg_i.line_max));
    in_half = (t > CMP_W'(cfg_i.half_min)) && (t < CMP_W'(cfg_i.half_max));
    // full-line window wins on overlap
    if (in_line) begin
      item_o.kind = KIND_LINE;
    end else if (in_half) begin
      item_o.kind = KIND_HALF;
    end else begin
      item_o.kind = KIND_NOISE;
    end
    item_o.good = in_line && (t < CMP_W'(cfg_i.good_max));
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

### hw/rtl/vsilt_queue.sv
// Short FIFO of classified items between front and back.
module vsilt_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vsilt_pkg::item_t push_item_i,
  input  logic             pop_i,
  output vsilt_pkg::item_t pop_item_o,
  output logic             empty_o,
  output logic             full_o
);
  import vsilt_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hw/rtl/vsilt_back.sv
// Back end: line, field and frame counters plus the result register.
module vsilt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vsilt_pkg::cfg_t  cfg_i,
  input  logic             q_empty_i,
  input  vsilt_pkg::item_t q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       interval_kind_o,
  output logic [15:0]      line_number_o,
  output logic             draw_line_o,
  output logic [15:0]      quality_score_o,
  output logic [15:0]      noise_count_o,
  output logic [7:0]       frame_count_o,
  output logic             field_active_o
);
  import vsilt_pkg::*;

  logic [15:0] line_q, line_d;
  logic [15:0] good_q, good_d;
  logic [15:0] qual_q, qual_d;
  logic [15:0] noise_q, noise_d;
  logic [7:0]  frame_q, frame_d;
  logic        field_q, field_d;
  logic        render_d;
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [15:0] line_out_q;
  logic        render_q;
  logic [15:0] qual_out_q;
  logic [15:0] noise_out_q;
  logic [7:0]  frame_out_q;
  logic        field_out_q;
  logic [15:0] line_inc;

  // Output slot frees up when empty or being taken this cycle.
  assign q_pop_o  = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign line_inc = line_q + 16'd1;

  always_comb begin
    line_d   = line_q;
    good_d   = good_q;
    qual_d   = qual_q;
    noise_d  = noise_q;
    frame_d  = frame_q;
    field_d  = field_q;
    render_d = 1'b0;
    unique case (q_item_i.kind)
      KIND_LINE: begin
        line_d   = line_inc;
        render_d = (line_inc <= {6'd0, cfg_i.last_render});
        field_d  = 1'b1;
        if (q_item_i.good) begin
          good_d = good_q + 16'd1;
        end
      end
      KIND_HALF: begin
        if (line_q > SHORT_FIELD_LINES) begin
          if (line_q > FULL_FIELD_LINES) begin
            qual_d  = good_q;
            noise_d = '0;
            frame_d = frame_q + 8'd1;
          end else begin
            qual_d = good_q + (PARTIAL_FIELD_BASE - line_q);
          end
          good_d = '0;
        end
        line_d  = '0;
        field_d = 1'b0;
      end
      default: begin
        noise_d = noise_q + 16'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      good_q      <= '0;
      qual_q      <= '0;
      noise_q     <= '0;
      frame_q     <= '0;
      field_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        line_q  <= line_d;
        good_q  <= good_d;
        qual_q  <= qual_d;
        noise_q <= noise_d;
        frame_q <= frame_d;
        field_q <= field_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q      <= q_item_i.kind;
      line_out_q  <= line_d;
      render_q    <= render_d;
      qual_out_q  <= qual_d;
      noise_out_q <= noise_d;
      frame_out_q <= frame_d;
      field_out_q <= field_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign interval_kind_o = kind_q;
  assign line_number_o   = line_out_q;
  assign draw_line_o     = render_q;
  assign quality_score_o = qual_out_q;
  assign noise_count_o   = noise_out_q;
  assign frame_count_o   = frame_out_q;
  assign field_active_o  = field_out_q;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the sync interval line tracker top level.
module testbench;
  import vsilt_pkg::*;

  localparam int         HALF_PERIOD   = 10;
  // Generous ceiling on simulation time for the whole run.
  localparam int         WATCHDOG_TIME = 200_000_000;
  // Margin past the queue and result register before touching the threshold registers.
  localparam int         SETTLE_CYCLES = 6;
  localparam int         DRAIN_LIMIT   = 5000;
  // Indexes past the register file; the block must drop these writes.
  localparam logic [2:0] CFG_SPARE_LO  = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI  = 3'd7;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  // One result item as seen on the output ports.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] line;
    logic        render;
    logic [15:0] quality;
    logic [15:0] noise;
    logic [7:0]  frames;
    logic        field;
  } verdict_t;

  // Shadow copy of the tracker: thresholds, counters and the verdicts still owed.
  class line_tracker_shadow;
    cfg_t        cfg;
    logic [15:0] lines;
    logic [15:0] good_lines;
    logic [15:0] quality;
    logic [15:0] noise;
    logic [7:0]  frames;
    logic        in_field;
    verdict_t    owed[$];
    int          errors;
    int          seen_count;

    function new();
      cfg.line_min    = RST_LINE_MIN;
      cfg.line_max    = RST_LINE_MAX;
      cfg.good_max    = RST_GOOD_MAX;
      cfg.half_min    = RST_HALF_MIN;
      cfg.half_max    = RST_HALF_MAX;
      cfg.last_render = RST_LAST_RENDER;
      lines      = '0;
      good_lines = '0;
      quality    = '0;
      noise      = '0;
      frames     = '0;
      in_field   = 1'b0;
      errors     = 0;
      seen_count = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [15:0] data);
      case (idx)
        CFG_LINE_MIN:    cfg.line_min    = data;
        CFG_LINE_MAX:    cfg.line_max    = data;
        CFG_GOOD_MAX:    cfg.good_max    = data;
        CFG_HALF_MIN:    cfg.half_min    = data;
        CFG_HALF_MAX:    cfg.half_max    = data;
        CFG_LAST_RENDER: cfg.last_render = data[9:0];
        default: ;
      endcase
    endfunction

    // Called for every accepted interval; queues the verdict it must produce.
    function void classify_interval(input logic [15:0] t);
      verdict_t v;
      v = '0;
      if (t > cfg.line_min && t < cfg.line_max) begin
        // line window wins where both windows overlap
        v.kind = KIND_LINE;
        lines++;
        v.render = (lines <= {6'd0, cfg.last_render});
        in_field = 1'b1;
        if (t < cfg.good_max) good_lines++;
      end else if (t > cfg.half_min && t < cfg.half_max) begin
        v.kind = KIND_HALF;
        if (lines > SHORT_FIELD_LINES) begin
          if (lines > FULL_FIELD_LINES) begin
            quality = good_lines;
            noise   = '0;
            frames++;
          end else begin
            quality = good_lines + (PARTIAL_FIELD_BASE - lines);
          end
          good_lines = '0;
        end
        lines    = '0;
        in_field = 1'b0;
      end else begin
        v.kind = KIND_NOISE;
        noise++;
      end
      v.line    = lines;
      v.quality = quality;
      v.noise   = noise;
      v.frames  = frames;
      v.field   = in_field;
      owed.push_back(v);
    endfunction

    task report(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_field(input string name, input logic [15:0] got,
                     input logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0d, want %0d", seen_count, name, got,
                         want));
    endtask

    task match_verdict(input verdict_t seen);
      verdict_t want;
      if (owed.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed (kind %0d line %0d)",
                         seen_count, seen.kind, seen.line));
      end else begin
        want = owed.pop_front();
        check_field("interval_kind", seen.kind, want.kind);
        check_field("line_number", seen.line, want.line);
        check_field("draw_line", seen.render, want.render);
        check_field("quality_score", seen.quality, want.quality);
        check_field("noise_count", seen.noise, want.noise);
        check_field("frame_count", seen.frames, want.frames);
        check_field("field_active", seen.field, want.field);
      end
      seen_count++;
    endtask
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [15:0] interval_ticks_i = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [1:0]  interval_kind_o;
  logic [15:0] line_number_o;
  logic        draw_line_o;
  logic [15:0] quality_score_o;
  logic [15:0] noise_count_o;
  logic [7:0]  frame_count_o;
  logic        field_active_o;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i      = '0;
  logic [15:0] cfg_data_i       = '0;

  line_tracker_shadow shadow;
  int sent          = 0;
  int burst_left    = 8;
  bit steady_sender = 1'b0;  // no gaps between items
  bit gentle_rx     = 1'b0;  // keep the receiver off its heaviest pattern

  video_sync_interval_line_tracker_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .interval_ticks_i (interval_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .interval_kind_o  (interval_kind_o),
    .line_number_o    (line_number_o),
    .draw_line_o      (draw_line_o),
    .quality_score_o  (quality_score_o),
    .noise_count_o    (noise_count_o),
    .frame_count_o    (frame_count_o),
    .field_active_o   (field_active_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Driver tasks. All inputs change by NBA right after a rising edge; the
  // handshake signals are sampled right after the edge, i.e. the values that
  // the block saw at that edge.
  // ---------------------------------------------------------------------------

  // Hold one item until accepted, then maybe open a gap between bursts.
  task automatic send_interval(input logic [15:0] t);
    in_valid_i       <= 1'b1;
    interval_ticks_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    shadow.classify_interval(t);
    sent++;
    if (!steady_sender) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        // mostly short bursts, now and then a long stretch with no idling
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
    end
  endtask

  // Leaves cfg_valid_i high so that back-to-back writes need one NBA per step.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    shadow.set_reg(idx, data);
  endtask

  // Only called with nothing in flight. Upper bits of the render limit are
  // filled with junk, which the block must mask off.
  task automatic program_regs(input cfg_t c, input bit with_spares);
    write_reg(CFG_LINE_MIN, c.line_min);
    write_reg(CFG_LINE_MAX, c.line_max);
    write_reg(CFG_GOOD_MAX, c.good_max);
    write_reg(CFG_HALF_MIN, c.half_min);
    write_reg(CFG_HALF_MAX, c.half_max);
    write_reg(CFG_LAST_RENDER, {6'($urandom), c.last_render});
    if (with_spares) begin
      write_reg(CFG_SPARE_LO, 16'($urandom));
      write_reg(CFG_SPARE_HI, 16'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Sender pauses until every owed result is back, then lets the pipe settle.
  task automatic drain();
    int k;
    in_valid_i <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && shadow.owed.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Value strictly inside an exclusive window, biased to its edges; anything
  // at all when the window is empty.
  function automatic logic [15:0] pick_between(input logic [15:0] lo,
                                               input logic [15:0] hi);
    int l = lo;
    int h = hi;
    if (h - l >= 2) begin
      case ($urandom_range(0, 9))
        0:       return 16'(l + 1);
        1:       return 16'(h - 1);
        default: return 16'($urandom_range(l + 1, h - 1));
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_line();
    if ($urandom_range(0, 6) == 0) return shadow.cfg.good_max;
    return pick_between(shadow.cfg.line_min, shadow.cfg.line_max);
  endfunction

  function automatic logic [15:0] pick_half();
    return pick_between(shadow.cfg.half_min, shadow.cfg.half_max);
  endfunction

  // Mostly anything; window bounds and rail values now and then.
  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return shadow.cfg.line_min;
      3:       return shadow.cfg.line_max;
      4:       return shadow.cfg.half_min;
      5:       return shadow.cfg.half_max;
      default: return 16'($urandom);
    endcase
  endfunction

  // Partial fields dominate; short fields are common, full ones rare here.
  function automatic int field_length();
    int r = $urandom_range(0, 19);
    if (r < 8) return $urandom_range(0, 10);
    if (r < 18) return $urandom_range(11, 60);
    if (r == 18) return $urandom_range(61, 300);
    return $urandom_range(301, 306);
  endfunction

  // One field: lines with the odd glitch in between, closed by a field pulse.
  task automatic send_field(input int n_lines);
    for (int i = 0; i < n_lines; i++) begin
      if ($urandom_range(0, 9) == 0) send_interval(pick_noise());
      send_interval(pick_line());
    end
    send_interval(pick_half());
  endtask

  // Fields are cut to the items left so the run stays near its budget.
  task automatic run_random(input int n_items);
    int goal;
    int n;
    goal = sent + n_items;
    while (sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1:    repeat ($urandom_range(1, 4)) send_interval(pick_noise());
        2:       send_interval(pick_half());
        default: begin
          n = field_length();
          if (n > goal - sent) n = goal - sent;
          send_field(n);
        end
      endcase
    end
  endtask

  function automatic cfg_t random_cfg();
    cfg_t        c;
    logic [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    c.line_min = (a < b) ? a : b;
    c.line_max = (a < b) ? b : a;
    c.good_max = 16'($urandom_range(c.line_min, c.line_max));
    a = 16'($urandom);
    b = 16'($urandom);
    c.half_min    = (a < b) ? a : b;
    c.half_max    = (a < b) ? b : a;
    c.last_render = 10'($urandom);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern of its own, switching mode at random spans
  // so stalls land on every phase of the block's work.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       tick;
    tick = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      if (gentle_rx && mode == RX_HEAVY) mode = RX_LIGHT;
      span = $urandom_range(16, 300);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          RX_FREE:  out_stall_i <= 1'b0;
          RX_LIGHT: out_stall_i <= ($urandom_range(0, 99) < 25);
          RX_HEAVY: out_stall_i <= ($urandom_range(0, 99) < 70);
          default:  out_stall_i <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  // Output monitor: every accepted result item is matched against the oldest
  // owed verdict.
  always @(posedge clk_i) begin : monitor
    verdict_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.kind    = kind_e'(interval_kind_o);
      seen.line    = line_number_o;
      seen.render  = draw_line_o;
      seen.quality = quality_score_o;
      seen.noise   = noise_count_o;
      seen.frames  = frame_count_o;
      seen.field   = field_active_o;
      shadow.match_verdict(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cfg_t c;
    shadow = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset thresholds. Field pulse with no lines (short field),
    // rail values, every exclusive window edge, good/not-good split, a short
    // field of four lines, then a partial field of twelve lines.
    send_interval(RST_HALF_MIN + 16'd70);
    send_interval(16'h0000);
    send_interval(16'hFFFF);
    send_interval(RST_LINE_MIN);
    send_interval(RST_LINE_MAX);
    send_interval(RST_HALF_MIN);
    send_interval(RST_HALF_MAX);
    send_interval(RST_LINE_MIN + 16'd1);
    send_interval(RST_GOOD_MAX - 16'd1);
    send_interval(RST_GOOD_MAX);
    send_interval(RST_LINE_MAX - 16'd1);
    send_interval(RST_HALF_MIN + 16'd1);
    repeat (12) send_interval(pick_line());
    send_interval(RST_HALF_MAX - 16'd1);
    drain();

    // Reset thresholds written back explicitly, plus writes to dead indexes.
    // Render limit 300, then one complete field with no sender gaps: line 301
    // is the first one not rendered, the noise count clears and a frame is
    // counted.
    c = shadow.cfg;
    c.last_render = 10'd300;
    program_regs(c, 1'b1);
    steady_sender = 1'b1;
    gentle_rx     = 1'b1;
    repeat (301) send_interval(pick_line());
    send_interval(pick_half());
    steady_sender = 1'b0;
    gentle_rx     = 1'b0;
    run_random(40);
    drain();

    // Overlapping windows: the line window must win inside the overlap.
    c.line_min    = 16'd4000;
    c.line_max    = 16'd6000;
    c.good_max    = 16'd5000;
    c.half_min    = 16'd4900;
    c.half_max    = 16'd5700;
    c.last_render = 10'd5;
    program_regs(c, 1'b0);
    run_random(40);
    drain();

    // Widest windows: everything but the rails is a line, all rendered.
    c.line_min    = 16'h0000;
    c.line_max    = 16'hFFFF;
    c.good_max    = 16'hFFFF;
    c.half_min    = 16'h0000;
    c.half_max    = 16'hFFFF;
    c.last_render = 10'h3FF;
    program_regs(c, 1'b1);
    run_random(30);
    drain();

    // Empty windows: every interval is noise, nothing rendered.
    c = '0;
    program_regs(c, 1'b0);
    run_random(20);
    drain();

    // Random threshold sets.
    repeat (3) begin
      program_regs(random_cfg(), 1'($urandom));
      run_random(25);
      drain();
    end

    if (shadow.owed.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.owed.size()));
    if (shadow.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_TIME);
    $display("Some tests failed");
    $finish;
  end

endmodule
